[rtl/dewu_pkg.sv]
// Shared types, codes and item layout for the digitizer event word unpacker.
package dewu_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CHAN_W   = 6;
  localparam int unsigned MOD_W    = 8;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned TS_W     = 46;
  localparam int unsigned TS_LO_W  = 30;
  localparam int unsigned EXT_W    = 16;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned PADDR_W  = 6;

  localparam logic [1:0] CLS_MISC    = 2'd0;
  localparam logic [1:0] CLS_HEADER  = 2'd1;
  localparam logic [1:0] CLS_ILLEGAL = 2'd2;
  localparam logic [1:0] CLS_FOOTER  = 2'd3;

  localparam logic [7:0] SUB_DUMMY = 8'h00;
  localparam logic [7:0] SUB_DATA  = 8'h10;
  localparam logic [7:0] SUB_EXT   = 8'h12;

  localparam logic [2:0] REG_DUP_BASE = 3'd4;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_UNKNOWN_MODULE = 3'd1,
    ST_NO_HEADER      = 3'd2,
    ST_BAD_CHANNEL    = 3'd3,
    ST_DUPLICATE      = 3'd4,
    ST_ILLEGAL_WORD   = 3'd5
  } status_t;

  typedef struct packed {
    logic [3:0][CFG_W-1:0] dup_check;
    logic [3:0][CFG_W-1:0] known_ids;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              ext_valid;
    logic [WORD_W-1:0] footer_word;
    logic [TS_W-1:0]   timestamp;
    logic [LEN_W-1:0]  event_length;
    logic [WORD_W-1:0] data_word;
    logic [CHAN_W-1:0] channel;
    logic [MOD_W-1:0]  mod_id;
    logic [1:0]        kind;
  } out_item_t;

  function automatic out_item_t mk_item(kind_t k, logic [MOD_W-1:0] mod,
                                        logic [CHAN_W-1:0] ch, logic [WORD_W-1:0] dw,
                                        logic [LEN_W-1:0] len, logic [TS_W-1:0] ts,
                                        logic [WORD_W-1:0] fw, logic ev, status_t st);
    out_item_t r;
    r.status       = st;
    r.ext_valid    = ev;
    r.footer_word  = fw;
    r.timestamp    = ts;
    r.event_length = len;
    r.data_word    = dw;
    r.channel      = ch;
    r.mod_id       = mod;
    r.kind         = k;
    return r;
  endfunction

endpackage

[rtl/dewu_cfg.sv]
// Configuration register file: module enable and duplicate-check masks.
module dewu_cfg
  import dewu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]   pwdata,
  output logic [CFG_W-1:0]   prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[PADDR_W-1:3];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      if (reg_idx < REG_DUP_BASE) begin
        cfg.known_ids[reg_idx[1:0]] <= pwdata;
      end else begin
        cfg.dup_check[reg_idx[1:0]] <= pwdata;
      end
    end
  end

  always_comb begin
    if (reg_idx < REG_DUP_BASE) begin
      prdata = cfg.known_ids[reg_idx[1:0]];
    end else begin
      prdata = cfg.dup_check[reg_idx[1:0]];
    end
  end

endmodule

[rtl/dewu_chan_mem.sv]
// Channel word store: one write port, one registered read port.
module dewu_chan_mem
  import dewu_pkg::*;
#(
  parameter int unsigned DEPTH  = 34,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/digitizer_event_word_unpacker_unit.sv]
// A status item is registered when its word is accepted and appears in the next cycle.
// Words that give no item or a status are taken one per cycle while the output is free.
// A footer scans the channel store one channel per cycle while none is stored; a stored
// channel also waits in S_WAIT for its store read and a free output; input is held off.
// Reset is synchronous: it clears the event state, present bits and config registers;
// the channel word store is not cleared.
module digitizer_event_word_unpacker_unit
  import dewu_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 34
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [31:0]        s_tdata,   // word[31:0]
  input  logic               s_tuser,   // first_of_buffer[0]
  output logic               m_tvalid,
  input  logic               m_tready,
  // mod_id[7:0] channel[13:8] data_word[45:14] event_length[57:46] timestamp[103:58]
  // footer_word[135:104] ext_valid[136] status[139:137] zero[143:140]
  output logic [143:0]       m_tdata,
  output logic [1:0]         m_tuser,   // kind[1:0]
  output logic               m_tlast,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]   pwdata,
  output logic [CFG_W-1:0]   prdata,
  output logic               pready
);

  localparam int unsigned CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned IDX_W = $clog2(NUM_CHANNELS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT} state_t;

  cfg_t cfg;

  state_t              state;
  logic [IDX_W-1:0]    idx;
  logic                out_valid;
  out_item_t           out_q;
  logic                out_last;
  logic                event_open;
  logic                buffer_aborted;
  logic [MOD_W-1:0]    current_module;
  logic                current_checks_dups;
  logic [WORD_W-1:0]   header_store;
  logic [EXT_W-1:0]    stamp_hi_store;
  logic                stamp_hi_seen;
  logic [NUM_CHANNELS-1:0] channel_present;
  logic [WORD_W-1:0]   footer_store;

  logic              accept;
  logic              slot_free;
  logic              open_eff;
  logic              abort_eff;
  logic [1:0]        cls;
  logic [7:0]        sub;
  logic [CHAN_W-1:0] wch;
  logic [CH_W-1:0]   ch_idx;
  logic [MOD_W-1:0]  hid;
  logic              id_known;
  logic              id_dup;
  logic              ch_ok;
  logic [CH_W-1:0]   idx_lo;
  logic              scan_done;
  logic              mem_re;
  logic              mem_we;
  logic [WORD_W-1:0] mem_rdata;

  logic              st_valid;
  status_t           st_code;
  logic [MOD_W-1:0]  st_mod;
  logic [CHAN_W-1:0] st_ch;
  logic              do_header;
  logic              do_store;
  logic              do_ext;
  logic              do_footer;
  logic              set_abort;
  logic              clr_open;

  dewu_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dewu_chan_mem #(
    .DEPTH  (NUM_CHANNELS),
    .ADDR_W (CH_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ch_idx),
    .wdata (s_tdata),
    .re    (mem_re),
    .raddr (idx_lo),
    .rdata (mem_rdata)
  );

  assign slot_free = !out_valid || m_tready;
  assign s_tready  = (state == S_IDLE) && slot_free;
  assign accept    = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {4'b0000, out_q.status, out_q.ext_valid, out_q.footer_word,
                      out_q.timestamp, out_q.event_length, out_q.data_word,
                      out_q.channel, out_q.mod_id};
  assign m_tuser   = out_q.kind;
  assign m_tlast   = out_last;

  assign open_eff  = event_open & ~s_tuser;
  assign abort_eff = buffer_aborted & ~s_tuser;
  assign cls       = s_tdata[31:30];
  assign sub       = s_tdata[29:22];
  assign wch       = s_tdata[21:16];
  assign hid       = s_tdata[23:16];
  assign ch_idx    = wch[CH_W-1:0];
  assign id_known  = cfg.known_ids[hid[7:6]][hid[5:0]];
  assign id_dup    = cfg.dup_check[hid[7:6]][hid[5:0]];
  assign ch_ok     = {1'b0, wch} < (CHAN_W+1)'(NUM_CHANNELS);

  assign idx_lo    = idx[CH_W-1:0];
  assign scan_done = (idx == IDX_W'(NUM_CHANNELS));
  assign mem_re    = (state == S_SCAN) && !scan_done && channel_present[idx_lo];
  assign mem_we    = accept && !abort_eff && do_store;

  always_comb begin
    st_valid  = 1'b0;
    st_code   = ST_OK;
    st_mod    = current_module;
    st_ch     = '0;
    do_header = 1'b0;
    do_store  = 1'b0;
    do_ext    = 1'b0;
    do_footer = 1'b0;
    set_abort = 1'b0;
    clr_open  = 1'b0;
    case (cls)
      CLS_HEADER: begin
        if (!id_known) begin
          st_valid  = 1'b1;
          st_code   = ST_UNKNOWN_MODULE;
          st_mod    = hid;
          set_abort = 1'b1;
          clr_open  = 1'b1;
        end else begin
          do_header = 1'b1;
        end
      end
      CLS_MISC: begin
        case (sub)
          SUB_DUMMY: begin
          end
          SUB_DATA: begin
            if (!open_eff) begin
              st_valid  = 1'b1;
              st_code   = ST_NO_HEADER;
              set_abort = 1'b1;
            end else if (!ch_ok) begin
              st_valid  = 1'b1;
              st_code   = ST_BAD_CHANNEL;
              st_ch     = wch;
              set_abort = 1'b1;
              clr_open  = 1'b1;
            end else if (current_checks_dups && channel_present[ch_idx]) begin
              st_valid = 1'b1;
              st_code  = ST_DUPLICATE;
              st_ch    = wch;
            end else begin
              do_store = 1'b1;
            end
          end
          SUB_EXT: begin
            if (!open_eff) begin
              st_valid  = 1'b1;
              st_code   = ST_NO_HEADER;
              set_abort = 1'b1;
            end else begin
              do_ext = 1'b1;
            end
          end
          default: begin
            st_valid = 1'b1;
            st_code  = ST_ILLEGAL_WORD;
          end
        endcase
      end
      CLS_FOOTER: begin
        if (!open_eff) begin
          st_valid  = 1'b1;
          st_code   = ST_NO_HEADER;
          set_abort = 1'b1;
        end else begin
          do_footer = 1'b1;
          clr_open  = 1'b1;
        end
      end
      default: begin
        st_valid = 1'b1;
        st_code  = ST_ILLEGAL_WORD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      idx                 <= '0;
      out_valid           <= 1'b0;
      out_last            <= 1'b0;
      event_open          <= 1'b0;
      buffer_aborted      <= 1'b0;
      current_module      <= '0;
      current_checks_dups <= 1'b0;
      header_store        <= '0;
      stamp_hi_store      <= '0;
      stamp_hi_seen       <= 1'b0;
      channel_present     <= '0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            event_open     <= open_eff;
            buffer_aborted <= abort_eff;
            if (!abort_eff) begin
              if (st_valid) begin
                out_valid <= 1'b1;
                out_last  <= 1'b1;
                out_q     <= mk_item(KIND_STATUS, st_mod, st_ch, s_tdata, '0, '0, '0,
                                     1'b0, st_code);
              end
              if (set_abort) begin
                buffer_aborted <= 1'b1;
              end
              if (clr_open) begin
                event_open <= 1'b0;
              end
              if (do_header) begin
                event_open          <= 1'b1;
                current_module      <= hid;
                current_checks_dups <= id_dup;
                header_store        <= s_tdata;
                stamp_hi_seen       <= 1'b0;
                stamp_hi_store      <= '0;
                channel_present     <= '0;
              end
              if (do_store) begin
                channel_present[ch_idx] <= 1'b1;
              end
              if (do_ext) begin
                stamp_hi_store <= s_tdata[EXT_W-1:0];
                stamp_hi_seen  <= 1'b1;
              end
              if (do_footer) begin
                footer_store <= s_tdata;
                idx          <= '0;
                state        <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            if (slot_free) begin
              out_valid <= 1'b1;
              out_last  <= 1'b1;
              out_q     <= mk_item(KIND_SUMMARY, current_module, '0, header_store,
                                   header_store[LEN_W-1:0],
                                   {(stamp_hi_seen ? stamp_hi_store : EXT_W'(0)),
                                    footer_store[TS_LO_W-1:0]},
                                   footer_store, stamp_hi_seen, ST_OK);
              state     <= S_IDLE;
            end
          end else if (channel_present[idx_lo]) begin
            state <= S_WAIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_WAIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_last  <= 1'b0;
            out_q     <= mk_item(KIND_DATA, current_module, CHAN_W'(idx), mem_rdata,
                                 '0, '0, '0, 1'b0, ST_OK);
            idx       <= idx + 1'b1;
            state     <= S_SCAN;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_wait_on_present: assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT |-> channel_present[idx_lo])
    else $error("store read pending for a channel with no stored word");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_q.kind == KIND_SUMMARY) |-> m_tlast)
    else $error("summary item without last");

  a_data_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_q.kind == KIND_DATA) |-> !m_tlast)
    else $error("channel item marked last");

  a_status_only_in_report: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_q.kind != KIND_STATUS) |-> out_q.status == ST_OK)
    else $error("nonzero status outside a status item");

  a_footer_enters_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && !abort_eff && do_footer) |=> (state == S_SCAN && idx == '0 && !event_open))
    else $error("footer did not start the channel scan");
`endif

endmodule
